// ===== sv/vrp_pkg.sv =====
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared constants, register codes and payload types of the vertex rotate and
// project block.
// ----------------------------------------------------------------------------
package vrp_pkg;

	localparam int COORD_W         = 24;
	localparam int TRIG_W          = 16;
	localparam int DIST_W          = 14;
	localparam int OFFS_W          = 12;
	localparam int SCREEN_W        = 16;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 16;
	localparam int COORD_FRAC_BITS = 8;
	localparam int TRIG_FRAC_BITS  = 14;

	// projection datapath
	localparam int DEN_W  = 25;                 // d*2^8 + z
	localparam int PROD_W = DIST_W + COORD_W;   // d*x and off*den
	localparam int NUM_W  = PROD_W + 1;         // d*x + off*den
	localparam int QUOT_W = SCREEN_W + 1;       // magnitude bits kept
	localparam int REM_W  = DEN_W + QUOT_W;     // widest trial subtract

	localparam int DIV_LAT  = QUOT_W;           // one quotient bit per stage
	localparam int SIDE_DLY = DIV_LAT - 1;      // s6 .. s21
	localparam int PIPE_DEPTH = 5 + DIV_LAT;    // s1 .. s22

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COS_Z  = 3'd0,
		CFG_SIN_Z  = 3'd1,
		CFG_COS_X  = 3'd2,
		CFG_SIN_X  = 3'd3,
		CFG_COS_Y  = 3'd4,
		CFG_SIN_Y  = 3'd5,
		CFG_DIST   = 3'd6,
		CFG_OFFSET = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0]  rot_x;
		logic signed [COORD_W-1:0]  rot_y;
		logic signed [COORD_W-1:0]  rot_z;
		logic signed [SCREEN_W-1:0] screen_x;
		logic signed [SCREEN_W-1:0] screen_y;
		logic                       zero_divisor;
		logic                       last_out;
	} res_t;

endpackage

// ===== sv/vrp_in_if.sv =====
// ----------------------------------------------------------------------------
// vrp_in_if
// Vertex input channel: valid/ready plus one vertex per beat.
// ----------------------------------------------------------------------------
interface vrp_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [vrp_pkg::COORD_W-1:0]  vert_x;
	logic signed [vrp_pkg::COORD_W-1:0]  vert_y;
	logic signed [vrp_pkg::COORD_W-1:0]  vert_z;
	logic                                last_vertex;

	modport source (output valid, vert_x, vert_y, vert_z, last_vertex, input ready);
	modport sink   (input valid, vert_x, vert_y, vert_z, last_vertex, output ready);
endinterface

// ===== sv/vrp_out_if.sv =====
// ----------------------------------------------------------------------------
// vrp_out_if
// Result channel: valid/ready plus rotated vertex and screen point per beat.
// ----------------------------------------------------------------------------
interface vrp_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [vrp_pkg::COORD_W-1:0]  rot_x;
	logic signed [vrp_pkg::COORD_W-1:0]  rot_y;
	logic signed [vrp_pkg::COORD_W-1:0]  rot_z;
	logic signed [vrp_pkg::SCREEN_W-1:0] screen_x;
	logic signed [vrp_pkg::SCREEN_W-1:0] screen_y;
	logic                                zero_divisor;
	logic                                last_out;

	modport source (output valid, rot_x, rot_y, rot_z, screen_x, screen_y,
		zero_divisor, last_out, input ready);
	modport sink   (input valid, rot_x, rot_y, rot_z, screen_x, screen_y,
		zero_divisor, last_out, output ready);
endinterface

// ===== sv/vrp_div.sv =====
// ----------------------------------------------------------------------------
// vrp_div
// Pipelined restoring divider: one quotient bit per stage, MSB first.
// ----------------------------------------------------------------------------
module vrp_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [vrp_pkg::NUM_W-1:0]     num,
	input  logic [vrp_pkg::DEN_W-1:0]     den,
	output logic [vrp_pkg::QUOT_W-1:0]    quot
);
	import vrp_pkg::*;

	logic [NUM_W-1:0]  rem_s [QUOT_W-1];
	logic [DEN_W-1:0]  den_s [QUOT_W-1];
	logic [QUOT_W-1:0] quo_s [QUOT_W];

	logic [NUM_W-1:0]  rem_in   [QUOT_W];
	logic [DEN_W-1:0]  den_in   [QUOT_W];
	logic [QUOT_W-1:0] quo_in   [QUOT_W];
	logic [REM_W-1:0]  trial    [QUOT_W];

	always_comb begin
		for (int j = 0; j < QUOT_W; j++) begin
			if (j == 0) begin
				rem_in[j] = num;
				den_in[j] = den;
				quo_in[j] = '0;
			end else begin
				rem_in[j] = rem_s[j-1];
				den_in[j] = den_s[j-1];
				quo_in[j] = quo_s[j-1];
			end
			trial[j] = {{(REM_W-NUM_W){1'b0}}, rem_in[j]}
				- ({{(REM_W-DEN_W){1'b0}}, den_in[j]} << (QUOT_W-1-j));
		end
	end

	// a borrow out of the trial subtract restores the remainder
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < QUOT_W; j++) begin
				quo_s[j] <= {quo_in[j][QUOT_W-2:0], ~trial[j][REM_W-1]};
				if (j < QUOT_W-1) begin
					rem_s[j] <= trial[j][REM_W-1] ? rem_in[j] : trial[j][NUM_W-1:0];
					den_s[j] <= den_in[j];
				end
			end
		end
	end

	assign quot = quo_s[QUOT_W-1];

endmodule

// ===== sv/vertex_rotate_and_project.sv =====
// ----------------------------------------------------------------------------
// vertex_rotate_and_project
// Perspective projection and Z-X-Y step rotation of one Q16.8 vertex per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Vertices arrive on vtx (valid/ready); one beat is one vertex. Each beat
//   yields exactly one beat on res: the screen point of the vertex as given,
//   and the vertex rotated about Z, then X, then Y for the next frame.
//   Throughput is one vertex per cycle while the skid is empty. res.valid
//   comes from 23 register stages, the first loaded by the vertex beat itself.
//   Four stages form the numerators and magnitudes, a 17 stage restoring
//   divider (one quotient bit per stage) sets the depth, then one stage of
//   signing and saturation and the output reg; the rotations finish early.
//   The cfg port writes one register per cycle; the user must write only while the
//   block is idle, which the block itself does not enforce. Reset clears all valid
//   bits and loads the register defaults (identity rotation, view distance -256,
//   offset 100); no clearing pass is needed. When res stalls, the output register
//   holds its beat and a one entry skid catches the next one; only with the skid
//   full does the whole pipeline freeze and vtx.ready drop. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module vertex_rotate_and_project (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [vrp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [vrp_pkg::CFG_DATA_W-1:0]    cfg_data,
	vrp_in_if.sink                            vtx,
	vrp_out_if.source                         res
);
	import vrp_pkg::*;

	typedef struct packed {
		logic signed [COORD_W-1:0] rx;
		logic signed [COORD_W-1:0] ry;
		logic signed [COORD_W-1:0] rz;
		logic                      last;
	} side_t;

	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic ovf_x;
		logic ovf_y;
		logic zero;
	} flag_t;

	localparam int PW = COORD_W + TRIG_W;   // one rotation product
	localparam int SW = PW + 1;             // sum of two products
	localparam int RW = SW - TRIG_FRAC_BITS;

	function automatic logic signed [COORD_W-1:0] rot_round(
		input logic signed [PW-1:0] a,
		input logic signed [PW-1:0] b,
		input logic                 sub
	);
		logic signed [SW-1:0] s;
		logic signed [RW-1:0] r;
		logic signed [RW-1:0] hi;
		logic signed [RW-1:0] lo;
		hi = RW'(2**(COORD_W-1) - 1);
		lo = -hi - RW'(1);
		s  = sub ? (SW'(a) - SW'(b)) : (SW'(a) + SW'(b));
		s  = s + (SW'(1) <<< (TRIG_FRAC_BITS-1));
		r  = RW'(s >>> TRIG_FRAC_BITS);
		if (r > hi)
			return COORD_W'(hi);
		else if (r < lo)
			return COORD_W'(lo);
		return COORD_W'(r);
	endfunction

	function automatic logic signed [SCREEN_W-1:0] scr_sat(
		input logic [QUOT_W-1:0] mag,
		input logic              neg,
		input logic              ovf
	);
		logic [QUOT_W-1:0] max_pos;
		max_pos = QUOT_W'(2**(SCREEN_W-1) - 1);
		if (ovf || (!neg && mag > max_pos) || (neg && mag > max_pos + QUOT_W'(1)))
			return neg ? SCREEN_W'(max_pos + QUOT_W'(1)) : SCREEN_W'(max_pos);
		return neg ? SCREEN_W'(-mag) : SCREEN_W'(mag);
	endfunction

	// configuration registers
	logic signed [TRIG_W-1:0] cos_z_q, sin_z_q, cos_x_q, sin_x_q, cos_y_q, sin_y_q;
	logic signed [DIST_W-1:0] dist_q;
	logic        [OFFS_W-1:0] offs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_z_q <= TRIG_W'(16384);
			sin_z_q <= '0;
			cos_x_q <= TRIG_W'(16384);
			sin_x_q <= '0;
			cos_y_q <= TRIG_W'(16384);
			sin_y_q <= '0;
			dist_q  <= -DIST_W'(256);
			offs_q  <= OFFS_W'(100);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_COS_Z:  cos_z_q <= cfg_data;
				CFG_SIN_Z:  sin_z_q <= cfg_data;
				CFG_COS_X:  cos_x_q <= cfg_data;
				CFG_SIN_X:  sin_x_q <= cfg_data;
				CFG_COS_Y:  cos_y_q <= cfg_data;
				CFG_SIN_Y:  sin_y_q <= cfg_data;
				CFG_DIST:   dist_q  <= cfg_data[DIST_W-1:0];
				CFG_OFFSET: offs_q  <= cfg_data[OFFS_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline control: the whole pipe moves unless the skid is occupied
	logic                  en;
	logic [PIPE_DEPTH-1:0] vld_s;
	logic                  out_vld_q, skid_vld_q;
	res_t                  out_q, skid_q;

	assign en        = !skid_vld_q;
	assign vtx.ready = en;

	// rotation path
	logic signed [PW-1:0]      pa_s1, pb_s1, pc_s1, pd_s1;
	logic signed [PW-1:0]      pa_s3, pb_s3, pc_s3, pd_s3;
	logic signed [PW-1:0]      pa_s5, pb_s5, pc_s5, pd_s5;
	logic signed [COORD_W-1:0] z_s1, z_s2, rx_s2, ry_s2, rx_s3, rx_s4, ry_s4, rz_s4, ry_s5;
	logic                      last_s1, last_s2, last_s3, last_s4, last_s5;
	side_t                     side_s [SIDE_DLY];

	// projection path
	logic signed [DEN_W-1:0]   den_s1, den_s2, den_s3;
	logic signed [PROD_W-1:0]  dx_s1, dy_s1, dx_s2, dy_s2, oden_s2;
	logic signed [NUM_W-1:0]   nx_s3, ny_s3;
	logic        [NUM_W-1:0]   nmx_s4, nmy_s4;
	logic        [DEN_W-1:0]   dmag_s4;
	logic                      nnx_s4, nny_s4, dneg_s4;
	flag_t                     flg_s [DIV_LAT];
	logic        [QUOT_W-1:0]  qx, qy;
	res_t                      fin_s22;

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: Z products, denominator, d*x and d*y
			pa_s1   <= vtx.vert_x * cos_z_q;
			pb_s1   <= vtx.vert_y * sin_z_q;
			pc_s1   <= vtx.vert_y * cos_z_q;
			pd_s1   <= vtx.vert_x * sin_z_q;
			z_s1    <= vtx.vert_z;
			last_s1 <= vtx.last_vertex;
			den_s1  <= (DEN_W'(dist_q) <<< COORD_FRAC_BITS) + DEN_W'(vtx.vert_z);
			dx_s1   <= dist_q * vtx.vert_x;
			dy_s1   <= dist_q * vtx.vert_y;
			// s2
			rx_s2   <= rot_round(pa_s1, pb_s1, 1'b1);
			ry_s2   <= rot_round(pc_s1, pd_s1, 1'b0);
			z_s2    <= z_s1;
			last_s2 <= last_s1;
			oden_s2 <= PROD_W'($signed({1'b0, offs_q}) * den_s1);
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			den_s2  <= den_s1;
			// s3: X products, full numerators
			pa_s3   <= z_s2 * cos_x_q;
			pb_s3   <= ry_s2 * sin_x_q;
			pc_s3   <= ry_s2 * cos_x_q;
			pd_s3   <= z_s2 * sin_x_q;
			rx_s3   <= rx_s2;
			last_s3 <= last_s2;
			nx_s3   <= NUM_W'(dx_s2) + NUM_W'(oden_s2);
			ny_s3   <= NUM_W'(dy_s2) + NUM_W'(oden_s2);
			den_s3  <= den_s2;
			// s4: magnitudes and signs
			rz_s4   <= rot_round(pa_s3, pb_s3, 1'b1);
			ry_s4   <= rot_round(pc_s3, pd_s3, 1'b0);
			rx_s4   <= rx_s3;
			last_s4 <= last_s3;
			nnx_s4  <= nx_s3[NUM_W-1];
			nny_s4  <= ny_s3[NUM_W-1];
			nmx_s4  <= nx_s3[NUM_W-1] ? NUM_W'(-nx_s3) : NUM_W'(nx_s3);
			nmy_s4  <= ny_s3[NUM_W-1] ? NUM_W'(-ny_s3) : NUM_W'(ny_s3);
			dneg_s4 <= den_s3[DEN_W-1];
			dmag_s4 <= den_s3[DEN_W-1] ? DEN_W'(-den_s3) : DEN_W'(den_s3);
			// s5: Y products, overflow test against den << QUOT_W
			pa_s5   <= rx_s4 * cos_y_q;
			pb_s5   <= rz_s4 * sin_y_q;
			pc_s5   <= rz_s4 * cos_y_q;
			pd_s5   <= rx_s4 * sin_y_q;
			ry_s5   <= ry_s4;
			last_s5 <= last_s4;
			flg_s[0].neg_x <= nnx_s4 ^ dneg_s4;
			flg_s[0].neg_y <= nny_s4 ^ dneg_s4;
			flg_s[0].ovf_x <= {{(REM_W-NUM_W){1'b0}}, nmx_s4} >= {dmag_s4, {QUOT_W{1'b0}}};
			flg_s[0].ovf_y <= {{(REM_W-NUM_W){1'b0}}, nmy_s4} >= {dmag_s4, {QUOT_W{1'b0}}};
			flg_s[0].zero  <= (dmag_s4 == '0);
			// s6: finished rotation, then hold it while the divider runs
			side_s[0].rx   <= rot_round(pa_s5, pb_s5, 1'b1);
			side_s[0].rz   <= rot_round(pc_s5, pd_s5, 1'b0);
			side_s[0].ry   <= ry_s5;
			side_s[0].last <= last_s5;
			for (int i = 1; i < SIDE_DLY; i++)
				side_s[i] <= side_s[i-1];
			for (int i = 1; i < DIV_LAT; i++)
				flg_s[i] <= flg_s[i-1];
			// s22: sign and saturate
			fin_s22.rot_x        <= side_s[SIDE_DLY-1].rx;
			fin_s22.rot_y        <= side_s[SIDE_DLY-1].ry;
			fin_s22.rot_z        <= side_s[SIDE_DLY-1].rz;
			fin_s22.last_out     <= side_s[SIDE_DLY-1].last;
			fin_s22.zero_divisor <= flg_s[DIV_LAT-1].zero;
			fin_s22.screen_x     <= scr_sat(qx, flg_s[DIV_LAT-1].neg_x, flg_s[DIV_LAT-1].ovf_x);
			fin_s22.screen_y     <= scr_sat(qy, flg_s[DIV_LAT-1].neg_y, flg_s[DIV_LAT-1].ovf_y);
		end
	end

	vrp_div u_div_x (.clk(clk), .en(en), .num(nmx_s4), .den(dmag_s4), .quot(qx));
	vrp_div u_div_y (.clk(clk), .en(en), .num(nmy_s4), .den(dmag_s4), .quot(qy));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[PIPE_DEPTH-2:0], vtx.valid};
	end

	// output register with a one beat skid behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || res.ready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q  <= vld_s[PIPE_DEPTH-1];
			end
		end else if (vld_s[PIPE_DEPTH-1]) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || res.ready)
			out_q <= skid_vld_q ? skid_q : fin_s22;
		else if (en)
			skid_q <= fin_s22;
	end

	assign res.valid        = out_vld_q;
	assign res.rot_x        = out_q.rot_x;
	assign res.rot_y        = out_q.rot_y;
	assign res.rot_z        = out_q.rot_z;
	assign res.screen_x     = out_q.screen_x;
	assign res.screen_y     = out_q.screen_y;
	assign res.zero_divisor = out_q.zero_divisor;
	assign res.last_out     = out_q.last_out;

endmodule

// ===== tb/sv/vrp_tb_if.sv =====
// ----------------------------------------------------------------------------
// vrp_tb_if
// Vertex item type for the vertex rotate and project testbench build.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
// The block's own interfaces (vrp_in_if, vrp_out_if) ship with the RTL and are
// used directly; this file holds the vertex item type the driver queues.
package vrp_tb_pkg;
	import vrp_pkg::*;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic                      last;
	} vertex_t;
endpackage

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams vertices through vertex_rotate_and_project with bursty input and a
// stalling output, predicts each rotated vertex and screen point, and compares
// every result beat in order. Several register settings are swept, extremes
// included, with writes only while the pipeline is drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
	import vrp_pkg::*;
	import vrp_tb_pkg::*;

	localparam int LATENCY  = 23;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	vrp_in_if  vtx ();
	vrp_out_if res ();

	vertex_rotate_and_project u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .vtx(vtx.sink), .res(res.source)
	);

	always #5 clk = ~clk;

	// shadow of the register file
	logic signed [TRIG_W-1:0] cos_z, sin_z, cos_x, sin_x, cos_y, sin_y;
	logic signed [DIST_W-1:0] view_dist;
	logic [OFFS_W-1:0]        offs;

	vertex_t pending_vertices[$];
	res_t    expected_results[$];

	int  mismatches = 0;
	int  beats_in = 0, beats_out = 0, zero_div_seen = 0, sat_seen = 0;
	int  idle_cycles = 0;
	bit  timed_out = 0;
	bit  long_hold = 0;

	function automatic logic signed [63:0] sat(input logic signed [63:0] v, input int w);
		logic signed [63:0] hi;
		hi = (64'sd1 <<< (w - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	// rounds half up then saturates to the coordinate width
	function automatic logic signed [63:0] rot_term(input logic signed [63:0] p);
		return sat((p + (64'sd1 <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS, COORD_W);
	endfunction

	function automatic logic signed [63:0] screen_coord(input logic signed [63:0] c,
			input logic signed [63:0] den);
		logic signed [63:0] num;
		num = 64'(view_dist) * c;
		if (den == 0) return (num < 0) ? -64'sd32768 : 64'sd32767;
		return sat((num + $signed(64'(offs)) * den) / den, SCREEN_W);
	endfunction

	function automatic res_t rotate_and_project(input vertex_t v);
		res_t r;
		logic signed [63:0] x, y, z, den, ax, ay, az, sx, sy;
		x = v.x; y = v.y; z = v.z;
		den = 64'(view_dist) * (64'sd1 <<< COORD_FRAC_BITS) + z;
		sx = screen_coord(x, den);
		sy = screen_coord(y, den);
		ax = rot_term(x * cos_z - y * sin_z);
		ay = rot_term(y * cos_z + x * sin_z);
		az = rot_term(z * cos_x - ay * sin_x);
		ay = rot_term(ay * cos_x + z * sin_x);
		r.rot_x = COORD_W'(rot_term(ax * cos_y - az * sin_y));
		r.rot_z = COORD_W'(rot_term(az * cos_y + ax * sin_y));
		r.rot_y = COORD_W'(ay);
		r.screen_x = SCREEN_W'(sx);
		r.screen_y = SCREEN_W'(sy);
		r.zero_divisor = (den == 0);
		r.last_out = v.last;
		return r;
	endfunction

	// driver: bursts of random length, random gaps
	int burst_left = 0, gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx.valid <= 1'b0;
			vtx.vert_x <= '0; vtx.vert_y <= '0; vtx.vert_z <= '0;
			vtx.last_vertex <= 1'b0;
		end else begin
			if (vtx.valid && vtx.ready) begin
				expected_results.push_back(rotate_and_project(pending_vertices.pop_front()));
				beats_in++;
			end
			if (!vtx.valid || vtx.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					vtx.valid <= 1'b0;
				end else if (pending_vertices.size() > 0) begin
					vtx.valid <= 1'b1;
					vtx.vert_x <= pending_vertices[0].x;
					vtx.vert_y <= pending_vertices[0].y;
					vtx.vert_z <= pending_vertices[0].z;
					vtx.last_vertex <= pending_vertices[0].last;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					vtx.valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern, plus one long hold-off on request
	int hold_left = 0;
	int stall_mode = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (long_hold && hold_left == 0) begin
				hold_left = 200;
				long_hold = 0;
			end
			if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 3);
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else begin
				case (stall_mode)
					0: res.ready <= 1'b1;
					1: res.ready <= ($urandom_range(0, 3) != 0);
					2: res.ready <= ($urandom_range(0, 1) != 0);
					default: res.ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			res_t got, want;
			got = '{res.rot_x, res.rot_y, res.rot_z, res.screen_x, res.screen_y,
				res.zero_divisor, res.last_out};
			beats_out++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %p", got);
			end else begin
				want = expected_results.pop_front();
				if (got.zero_divisor) zero_div_seen++;
				if (got.screen_x == 16'sh7fff || got.screen_x == -16'sh8000) sat_seen++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at beat %0d: expected %p, got %p",
							beats_out, want, got);
				end
			end
		end
	end

	// watchdog on cycles with no accepted beat
	always @(posedge clk) begin
		if ((vtx.valid && vtx.ready) || (res.valid && res.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog expired with %0d results outstanding",
				expected_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_COS_Z:  cos_z = val;
			CFG_SIN_Z:  sin_z = val;
			CFG_COS_X:  cos_x = val;
			CFG_SIN_X:  sin_x = val;
			CFG_COS_Y:  cos_y = val;
			CFG_SIN_Y:  sin_y = val;
			CFG_DIST:   view_dist = val[DIST_W-1:0];
			default:    offs = val[OFFS_W-1:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (pending_vertices.size() > 0 || expected_results.size() > 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return COORD_W'($urandom);
			1: return $urandom_range(0, 1) ? 24'sh7fffff : -24'sh800000;
			2: return $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
			default: return $signed(24'($urandom_range(0, 131071))) - 24'sd65536;
		endcase
	endfunction

	task automatic queue_vertex(input logic signed [COORD_W-1:0] x, y, z, input logic l);
		vertex_t v;
		v.x = x; v.y = y; v.z = z; v.last = l;
		pending_vertices.push_back(v);
	endtask

	// random frame; some vertices aimed at d+z == 0
	task automatic queue_frame(input int n);
		logic signed [COORD_W-1:0] z;
		for (int i = 0; i < n; i++) begin
			z = rand_coord();
			if ($urandom_range(0, 15) == 0) z = -(COORD_W'(view_dist) <<< COORD_FRAC_BITS);
			queue_vertex(rand_coord(), rand_coord(), z, i == n - 1);
		end
	endtask

	function automatic logic [CFG_DATA_W-1:0] rand_trig();
		case ($urandom_range(0, 4))
			0: return 16'sh4000;
			1: return -16'sh4000;
			2: return CFG_DATA_W'($urandom);
			default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
		endcase
	endfunction

	initial begin
		cos_z = 16'sd16384; sin_z = 16'sd0; cos_x = 16'sd16384; sin_x = 16'sd0;
		cos_y = 16'sd16384; sin_y = 16'sd0;
		view_dist = -14'sd256; offs = 12'd100;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// identity and zero divisor at reset settings
		queue_vertex(0, 0, 0, 0);
		queue_vertex(24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 0);
		queue_vertex(-24'sh800000, -24'sh800000, -24'sh800000, 0);
		queue_vertex(24'sh000100, -24'sh000100, 24'sd65536, 0);
		queue_vertex(24'sh001000, -24'sh001000, 24'sd65536, 0);
		queue_vertex(24'sh000000, 24'sh000000, 24'sd65536, 0);
		queue_vertex(-24'sh000200, 24'sh000300, 24'sd65535, 1);
		queue_vertex(24'sh555555, -24'sh2aaaab, 24'sh123456, 1);
		drain();

		// extreme registers, out of range trig values included
		write_reg(CFG_COS_Z, 16'sh7fff); write_reg(CFG_SIN_Z, 16'sh8000);
		write_reg(CFG_COS_X, -16'sh4000); write_reg(CFG_SIN_X, 16'sh4000);
		write_reg(CFG_COS_Y, 16'sh0000); write_reg(CFG_SIN_Y, -16'sh4000);
		write_reg(CFG_DIST, 16'h1fff); write_reg(CFG_OFFSET, 16'h0fff);
		queue_vertex(24'sh7fffff, -24'sh800000, 24'sh7fffff, 0);
		queue_vertex(-24'sh800000, 24'sh7fffff, -24'sh1fff00, 0);
		queue_vertex(24'sh400000, 24'sh400000, -24'sh800000, 0);
		queue_vertex(1, -1, 1, 1);
		drain();
		write_reg(CFG_DIST, 16'h2000); write_reg(CFG_OFFSET, 16'h0000);
		queue_vertex(-24'sh800000, 24'sh7fffff, 24'sh200000, 0);
		queue_vertex(24'sh123456, -24'sh654321, 24'sh200000, 0);
		queue_vertex(24'sh7fffff, 24'sh7fffff, -24'sh800000, 1);
		drain();
		write_reg(CFG_DIST, 16'h0000);
		queue_vertex(24'sh7fffff, -24'sh100, 0, 1);
		queue_vertex(24'sh100, 0, 24'sh100, 0);
		drain();

		// random phases: new settings, then frames
		for (int phase = 0; phase < 12; phase++) begin
			write_reg(CFG_COS_Z, rand_trig()); write_reg(CFG_SIN_Z, rand_trig());
			write_reg(CFG_COS_X, rand_trig()); write_reg(CFG_SIN_X, rand_trig());
			write_reg(CFG_COS_Y, rand_trig()); write_reg(CFG_SIN_Y, rand_trig());
			write_reg(CFG_DIST, $urandom_range(0, 2) == 0 ? 16'($urandom)
				: 16'($signed(16'($urandom_range(0, 8192))) - 16'sd4096));
			write_reg(CFG_OFFSET, 16'($urandom));
			for (int f = 0; f < 8; f++) queue_frame($urandom_range(1, 24));
			if (phase == 5) long_hold = 1;
			drain();
		end

		$display("%0d vertices in, %0d results out over 16 register settings",
			beats_in, beats_out);
		$display("%0d zero divisor results, %0d saturated screen_x values",
			zero_div_seen, sat_seen);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
